// ===== hdl/assert_macros.svh =====
// assertion macros shared by the knn top-k vote block
// no dependencies; taken in by `include in the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/knn_pkg.sv =====
// types, widths and defaults for the knn top-k vote block
// no dependencies; used by knn_dist, knn_cell, knn_vote and knn_top_k_vote
`default_nettype none

package knn_pkg;

   localparam int NUM_FEATURES     = 8;
   localparam int FEATURE_W        = 16;
   localparam int DIFF_W           = 17;
   localparam int SQ_W             = 32;
   localparam int DIST_W           = 36;
   localparam int LABEL_W          = 8;
   localparam int FC_W             = 4;
   localparam int VOTE_W           = 3;
   localparam int DEF_NEIGHBORS    = 5;
   localparam int DEF_MAX_FEATURES = 8;
   localparam logic [FC_W-1:0] FC_RESET = 4'd8;

   typedef logic signed [FEATURE_W-1:0] feature_type;

   typedef struct packed {
      logic               valid;
      logic [DIST_W-1:0]  distance;
      logic [LABEL_W-1:0] label;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIST,
      ST_VOTE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/knn_top_k_vote.sv =====
// k-nearest-neighbour classifier: query load, streaming top-k insertion chain, majority vote
// depends on knn_pkg, knn_dist, knn_cell, knn_vote and assert_macros.svh
//
// A beat with mode 0 loads the query vector and empties the neighbour list in its accept
// cycle. A beat with mode 1 is a training sample: the distance unit squares one feature
// difference per cycle over feature_count features, feature_count being clamped to
// MAX_FEATURES, and no further request is taken until the chain of NEIGHBORS cells has
// inserted the sample. A beat with last_sample set adds a vote, one candidate slot per
// cycle, before the result beat is written to the output register. The result register
// lets the next request be taken while a result waits. The user must write feature_count
// through the csr port only while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module knn_top_k_vote #(
   parameter int NEIGHBORS    = knn_pkg::DEF_NEIGHBORS,
   parameter int MAX_FEATURES = knn_pkg::DEF_MAX_FEATURES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [knn_pkg::FC_W-1:0]      csr_feature_count,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_0,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_1,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_2,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_3,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_4,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_5,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_6,
   input  wire logic signed [knn_pkg::FEATURE_W-1:0] req_feature_7,
   input  wire logic [knn_pkg::LABEL_W-1:0]   req_class_label,
   input  wire logic                          req_last_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [knn_pkg::LABEL_W-1:0]        rsp_predicted_label,
   output logic [knn_pkg::VOTE_W-1:0]         rsp_vote_count,
   output logic                               rsp_no_neighbors
);

   localparam int CNT_W = $clog2(MAX_FEATURES + 1);
   localparam int CW    = $clog2(NEIGHBORS + 1);
   localparam int FW    = knn_pkg::FC_W;
   localparam int VW    = knn_pkg::VOTE_W;
   localparam int NF    = knn_pkg::NUM_FEATURES;

   knn_pkg::state_type        state_ff;
   knn_pkg::state_type        state_in;
   knn_pkg::cell_ctrl_type    cell_ctrl;
   logic [FW-1:0]             fc_ff;
   logic [CNT_W-1:0]          fc_use;
   knn_pkg::feature_type      req_feat  [NF];
   knn_pkg::feature_type      query_ff  [MAX_FEATURES];
   knn_pkg::feature_type      sample_ff [MAX_FEATURES];
   logic [knn_pkg::LABEL_W-1:0] label_ff;
   logic                      last_ff;
   logic                      accept;
   logic                      dist_start;
   logic                      dist_done;
   logic [knn_pkg::DIST_W-1:0] dist_val;
   knn_pkg::entry_type        new_entry;
   knn_pkg::entry_type        entries [NEIGHBORS];
   logic                      takes   [NEIGHBORS];
   logic                      vote_done;
   logic [knn_pkg::LABEL_W-1:0] vote_label;
   logic [CW-1:0]             vote_cnt;
   logic                      rsp_load;
   logic                      rsp_valid_ff;
   logic [knn_pkg::LABEL_W-1:0] rsp_label_ff;
   logic [VW-1:0]             rsp_cnt_ff;
   logic                      rsp_none_ff;

   assign req_feat[0] = req_feature_0;
   assign req_feat[1] = req_feature_1;
   assign req_feat[2] = req_feature_2;
   assign req_feat[3] = req_feature_3;
   assign req_feat[4] = req_feature_4;
   assign req_feat[5] = req_feature_5;
   assign req_feat[6] = req_feature_6;
   assign req_feat[7] = req_feature_7;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == knn_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fc_use    = (fc_ff > FW'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES) : CNT_W'(fc_ff);
   assign new_entry = '{valid: 1'b1, distance: dist_val, label: label_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= knn_pkg::FC_RESET;
      end else if (csr_valid) begin
         fc_ff <= csr_feature_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            query_ff[i] <= '0;
         end
      end else if (accept && !req_mode) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            query_ff[i] <= req_feat[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            sample_ff[i] <= req_feat[i];
         end
         label_ff <= req_class_label;
         last_ff  <= req_last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cell_ctrl  = '0;
      dist_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         knn_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  dist_start = 1'b1;
                  state_in   = knn_pkg::ST_DIST;
               end else begin
                  cell_ctrl.clear = 1'b1;
                  state_in = req_last_sample ? knn_pkg::ST_VOTE : knn_pkg::ST_IDLE;
               end
            end
         end
         knn_pkg::ST_DIST: begin
            if (dist_done) begin
               cell_ctrl.insert = 1'b1;
               state_in = last_ff ? knn_pkg::ST_VOTE : knn_pkg::ST_IDLE;
            end
         end
         knn_pkg::ST_VOTE: begin
            if (vote_done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               state_in = knn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = knn_pkg::ST_IDLE;
         end
      endcase
   end

   knn_dist #(
      .MAX_FEATURES (MAX_FEATURES),
      .CNT_W        (CNT_W)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .start      (dist_start),
      .feat_count (fc_use),
      .query      (query_ff),
      .sample     (sample_ff),
      .done       (dist_done),
      .distance   (dist_val)
   );

   for (genvar i = 0; i < NEIGHBORS; i++) begin : g_cell
      if (i == 0) begin : g_head
         knn_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .new_entry  (new_entry),
            .prev_entry ('0),
            .prev_take  (1'b0),
            .take       (takes[i]),
            .entry      (entries[i])
         );
      end else begin : g_link
         knn_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .new_entry  (new_entry),
            .prev_entry (entries[i-1]),
            .prev_take  (takes[i-1]),
            .take       (takes[i]),
            .entry      (entries[i])
         );
         `ASSERT_ALWAYS(a_sorted, clock, reset, entries[i].valid |-> (entries[i-1].valid && (entries[i-1].distance <= entries[i].distance)), "neighbour list out of order")
      end
   end

   knn_vote #(
      .NEIGHBORS (NEIGHBORS),
      .CW        (CW)
   ) u_vote (
      .clock   (clock),
      .reset   (reset),
      .run     (state_ff == knn_pkg::ST_VOTE),
      .entries (entries),
      .done    (vote_done),
      .label   (vote_label),
      .count   (vote_cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_label_ff <= vote_label;
         rsp_cnt_ff   <= VW'(vote_cnt);
         rsp_none_ff  <= (vote_cnt == '0);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_label = rsp_label_ff;
   assign rsp_vote_count      = rsp_cnt_ff;
   assign rsp_no_neighbors    = rsp_none_ff;

   `ASSERT_ALWAYS(a_rsp_from_vote, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == knn_pkg::ST_VOTE), "result beat without a vote")
   `ASSERT_NEVER(a_insert_clear, clock, reset, cell_ctrl.insert && cell_ctrl.clear, "insert and clear together")

endmodule

`default_nettype wire

// ===== hdl/knn_dist.sv =====
// squared distance unit: one feature difference squared per cycle, then accumulated
// depends on knn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module knn_dist #(
   parameter int MAX_FEATURES = knn_pkg::DEF_MAX_FEATURES,
   parameter int CNT_W        = $clog2(MAX_FEATURES + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [CNT_W-1:0]           feat_count,
   input  knn_pkg::feature_type            query  [MAX_FEATURES],
   input  knn_pkg::feature_type            sample [MAX_FEATURES],
   output logic                            done,
   output logic [knn_pkg::DIST_W-1:0]      distance
);

   localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int DW     = knn_pkg::DIFF_W;
   localparam int SW     = knn_pkg::SQ_W;
   localparam int TW     = knn_pkg::DIST_W;

   logic                 run_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [SW-1:0]        prod_ff;
   logic [SW-1:0]        prod_in;
   logic                 pv_ff;
   logic                 plast_ff;
   logic [TW-1:0]        acc_ff;
   logic                 done_ff;
   logic                 last_in;
   logic [FIDX_W-1:0]    idx;
   logic signed [DW-1:0] diff;
   logic signed [2*DW-1:0] sq;

   always_comb begin
      idx     = cnt_ff[FIDX_W-1:0];
      diff    = DW'(query[idx]) - DW'(sample[idx]);
      sq      = diff * diff;
      prod_in = sq[SW-1:0];
      last_in = (cnt_ff + CNT_W'(1)) == feat_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         pv_ff    <= run_ff;
         plast_ff <= run_ff && last_in;
         done_ff  <= (start && (feat_count == '0)) || (pv_ff && plast_ff);
         if (start) begin
            run_ff <= (feat_count != '0);
         end else if (run_ff && last_in) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (start) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (pv_ff) begin
            acc_ff <= acc_ff + TW'(prod_ff);
         end
      end
   end

   assign done     = done_ff;
   assign distance = acc_ff;

   `ASSERT_ALWAYS(a_done_single, clock, reset, done_ff |=> !done_ff, "distance done held twice")

endmodule

`default_nettype wire

// ===== hdl/knn_cell.sv =====
// one slot of the sorted neighbour list; takes the new sample or its upper neighbour's entry
// depends on knn_pkg
`default_nettype none

module knn_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  knn_pkg::cell_ctrl_type     ctrl,
   input  knn_pkg::entry_type         new_entry,
   input  knn_pkg::entry_type         prev_entry,
   input  wire logic                  prev_take,
   output logic                       take,
   output knn_pkg::entry_type         entry
);

   logic                          valid_ff;
   logic [knn_pkg::DIST_W-1:0]    dist_ff;
   logic [knn_pkg::LABEL_W-1:0]   label_ff;

   assign take = !valid_ff || (new_entry.distance < dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.insert) begin
         if (prev_take) begin
            valid_ff <= prev_entry.valid;
         end else if (take) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         if (prev_take) begin
            dist_ff  <= prev_entry.distance;
            label_ff <= prev_entry.label;
         end else if (take) begin
            dist_ff  <= new_entry.distance;
            label_ff <= new_entry.label;
         end
      end
   end

   assign entry = '{valid: valid_ff, distance: dist_ff, label: label_ff};

endmodule

`default_nettype wire

// ===== hdl/knn_vote.sv =====
// majority vote over the neighbour list, one candidate slot per cycle
// depends on knn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module knn_vote #(
   parameter int NEIGHBORS = knn_pkg::DEF_NEIGHBORS,
   parameter int CW        = $clog2(NEIGHBORS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     run,
   input  knn_pkg::entry_type            entries [NEIGHBORS],
   output logic                          done,
   output logic [knn_pkg::LABEL_W-1:0]   label,
   output logic [CW-1:0]                 count
);

   localparam int VIDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int LW     = knn_pkg::LABEL_W;

   logic [VIDX_W-1:0]  idx_ff;
   logic               done_ff;
   logic [LW-1:0]      best_label_ff;
   logic [CW-1:0]      best_cnt_ff;
   knn_pkg::entry_type cand;
   logic [CW-1:0]      match_cnt;
   logic               better;
   logic               any_valid;

   always_comb begin
      cand      = entries[idx_ff];
      match_cnt = '0;
      any_valid = 1'b0;
      for (int j = 0; j < NEIGHBORS; j++) begin
         if (entries[j].valid && (entries[j].label == cand.label)) begin
            match_cnt = match_cnt + CW'(1);
         end
         any_valid = any_valid | entries[j].valid;
      end
      better = cand.valid && ((match_cnt > best_cnt_ff) ||
               ((match_cnt == best_cnt_ff) && (cand.label < best_label_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset || !run) begin
         idx_ff        <= '0;
         done_ff       <= 1'b0;
         best_label_ff <= '0;
         best_cnt_ff   <= '0;
      end else if (!done_ff) begin
         if (better) begin
            best_label_ff <= cand.label;
            best_cnt_ff   <= match_cnt;
         end
         if (idx_ff == VIDX_W'(NEIGHBORS - 1)) begin
            done_ff <= 1'b1;
         end else begin
            idx_ff <= idx_ff + VIDX_W'(1);
         end
      end
   end

   assign done  = done_ff;
   assign label = best_label_ff;
   assign count = best_cnt_ff;

   `ASSERT_ALWAYS(a_empty_vote, clock, reset, (done_ff && (best_cnt_ff == '0)) |-> !any_valid, "zero vote with valid neighbours")

endmodule

`default_nettype wire

// ===== tb/tb_knn_top_k_vote.sv =====
// self-checking testbench for the knn top-k vote block: streams query and sample beats,
// predicts each vote result and compares it with the result channel
// depends on knn_pkg and knn_top_k_vote
module tb_knn_top_k_vote;

   localparam logic MODE_QUERY    = 1'b0;
   localparam logic MODE_SAMPLE   = 1'b1;
   localparam int   LIST_LEN      = knn_pkg::DEF_NEIGHBORS;
   localparam int   NUM_PHASES    = 7;
   localparam int   PHASE_BEATS   = 200;
   localparam int   SETTLE_CYCLES = 40;
   localparam int   CYCLE_LIMIT   = 600000;

   typedef enum {
      FEAT_RANDOM,
      FEAT_CLOSE,
      FEAT_NEAR,
      FEAT_EXTREME,
      FEAT_REPEAT,
      FEAT_FILL
   } feat_kind_type;

   typedef struct {
      logic                        mode;
      knn_pkg::feature_type        feat [knn_pkg::NUM_FEATURES];
      logic [knn_pkg::LABEL_W-1:0] label;
      logic                        last;
   } sample_beat_type;

   typedef struct packed {
      logic [knn_pkg::LABEL_W-1:0] label;
      logic [knn_pkg::VOTE_W-1:0]  votes;
      logic                        empty;
   } vote_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [knn_pkg::FC_W-1:0]    csr_feature_count = '0;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_mode = 1'b0;
   knn_pkg::feature_type        req_feature [knn_pkg::NUM_FEATURES] = '{default: '0};
   logic [knn_pkg::LABEL_W-1:0] req_class_label = '0;
   logic                        req_last_sample = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [knn_pkg::LABEL_W-1:0] rsp_predicted_label;
   logic [knn_pkg::VOTE_W-1:0]  rsp_vote_count;
   logic                        rsp_no_neighbors;

   // predictor state
   logic [knn_pkg::FC_W-1:0]    model_fc = knn_pkg::FC_RESET;
   knn_pkg::feature_type        model_query [knn_pkg::NUM_FEATURES] = '{default: '0};
   logic [knn_pkg::DIST_W-1:0]  nb_dist  [LIST_LEN] = '{default: '0};
   logic [knn_pkg::LABEL_W-1:0] nb_label [LIST_LEN] = '{default: '0};
   logic                        nb_valid [LIST_LEN] = '{default: 1'b0};

   vote_type           expected_votes [$];
   sample_beat_type    beats_pending [$];
   sample_beat_type    req_cur;
   logic               req_taken = 1'b0;
   int                 beats_queued = 0;
   int                 beats_taken = 0;
   int                 errors = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   // generator view of the current query and the previous sample
   knn_pkg::feature_type gen_query [knn_pkg::NUM_FEATURES] = '{default: '0};
   knn_pkg::feature_type gen_prev  [knn_pkg::NUM_FEATURES] = '{default: '0};

   knn_top_k_vote i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_feature_count   (csr_feature_count),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_feature_0       (req_feature[0]),
      .req_feature_1       (req_feature[1]),
      .req_feature_2       (req_feature[2]),
      .req_feature_3       (req_feature[3]),
      .req_feature_4       (req_feature[4]),
      .req_feature_5       (req_feature[5]),
      .req_feature_6       (req_feature[6]),
      .req_feature_7       (req_feature[7]),
      .req_class_label     (req_class_label),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_label (rsp_predicted_label),
      .rsp_vote_count      (rsp_vote_count),
      .rsp_no_neighbors    (rsp_no_neighbors)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [knn_pkg::DIST_W-1:0] distance_to_query(sample_beat_type b);
      int     n;
      longint sum;
      longint d;
      n = (model_fc > knn_pkg::DEF_MAX_FEATURES) ? knn_pkg::DEF_MAX_FEATURES : int'(model_fc);
      sum = 0;
      for (int i = 0; i < n; i++) begin
         d = longint'(model_query[i]) - longint'(b.feat[i]);
         sum += d * d;
      end
      return sum[knn_pkg::DIST_W-1:0];
   endfunction

   function automatic void insert_neighbour(logic [knn_pkg::DIST_W-1:0] new_dist,
                                            logic [knn_pkg::LABEL_W-1:0] label);
      int pos;
      pos = LIST_LEN;
      for (int i = LIST_LEN - 1; i >= 0; i--)
         if (!nb_valid[i] || new_dist < nb_dist[i]) pos = i;
      if (pos < LIST_LEN) begin
         for (int k = LIST_LEN - 1; k > pos; k--) begin
            nb_dist[k]  = nb_dist[k-1];
            nb_label[k] = nb_label[k-1];
            nb_valid[k] = nb_valid[k-1];
         end
         nb_dist[pos]  = new_dist;
         nb_label[pos] = label;
         nb_valid[pos] = 1'b1;
      end
   endfunction

   function automatic vote_type majority_vote();
      vote_type                    r;
      int                          cnt;
      int                          best_cnt;
      logic [knn_pkg::LABEL_W-1:0] best_label;
      best_cnt   = 0;
      best_label = '0;
      for (int i = 0; i < LIST_LEN; i++) begin
         if (nb_valid[i]) begin
            cnt = 0;
            for (int j = 0; j < LIST_LEN; j++)
               if (nb_valid[j] && nb_label[j] == nb_label[i]) cnt++;
            if (cnt > best_cnt || (cnt == best_cnt && nb_label[i] < best_label)) begin
               best_cnt   = cnt;
               best_label = nb_label[i];
            end
         end
      end
      r.label = best_label;
      r.votes = best_cnt[knn_pkg::VOTE_W-1:0];
      r.empty = (best_cnt == 0);
      return r;
   endfunction

   function automatic void apply_beat(sample_beat_type b);
      if (b.mode == MODE_QUERY) begin
         model_query = b.feat;
         nb_dist  = '{default: '0};
         nb_label = '{default: '0};
         nb_valid = '{default: 1'b0};
      end else begin
         insert_neighbour(distance_to_query(b), b.label);
      end
      if (b.last) expected_votes.push_back(majority_vote());
   endfunction

   function automatic knn_pkg::feature_type rand_feature();
      logic [31:0] r;
      r = $urandom();
      return r[knn_pkg::FEATURE_W-1:0];
   endfunction

   function automatic knn_pkg::feature_type near_value(knn_pkg::feature_type centre, int spread);
      int v;
      v = int'(centre) + int'($urandom_range(2 * spread)) - spread;
      return v[knn_pkg::FEATURE_W-1:0];
   endfunction

   function automatic void push_beat(logic mode, feat_kind_type kind,
                                     logic [knn_pkg::LABEL_W-1:0] label,
                                     logic last, knn_pkg::feature_type fill = '0);
      sample_beat_type b;
      b.mode  = mode;
      b.label = label;
      b.last  = last;
      for (int i = 0; i < knn_pkg::NUM_FEATURES; i++) begin
         case (kind)
            FEAT_CLOSE:   b.feat[i] = near_value(gen_query[i], 3);
            FEAT_NEAR:    b.feat[i] = near_value(gen_query[i], 2000);
            FEAT_EXTREME: b.feat[i] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            FEAT_REPEAT:  b.feat[i] = gen_prev[i];
            FEAT_FILL:    b.feat[i] = fill;
            default:      b.feat[i] = rand_feature();
         endcase
      end
      if (mode == MODE_QUERY) gen_query = b.feat;
      else gen_prev = b.feat;
      beats_pending.push_back(b);
      beats_queued++;
   endfunction

   function automatic feat_kind_type pick_sample_kind();
      int r;
      r = $urandom_range(99);
      if (r < 30) return FEAT_CLOSE;
      if (r < 60) return FEAT_NEAR;
      if (r < 80) return FEAT_RANDOM;
      if (r < 90) return FEAT_REPEAT;
      return FEAT_EXTREME;
   endfunction

   function automatic logic [knn_pkg::LABEL_W-1:0] pick_label(logic wide);
      return wide ? knn_pkg::LABEL_W'($urandom_range(255))
                  : knn_pkg::LABEL_W'($urandom_range(3));
   endfunction

   // mostly a query, a run of samples and a vote, sometimes topped up and voted again
   function automatic void push_random_round();
      int            n;
      int            r;
      logic          wide;
      feat_kind_type qkind;
      if ($urandom_range(99) < 85) begin
         wide = ($urandom_range(3) == 0);
         r = $urandom_range(99);
         qkind = (r < 70) ? FEAT_RANDOM : (r < 85) ? FEAT_EXTREME : FEAT_NEAR;
         push_beat(MODE_QUERY, qkind, pick_label(1'b1), 1'b0);
         n = ($urandom_range(9) == 0) ? $urandom_range(16, 6) : $urandom_range(6, 1);
         for (int i = 1; i <= n; i++)
            push_beat(MODE_SAMPLE, pick_sample_kind(), pick_label(wide), i == n);
         if ($urandom_range(3) == 0) begin
            n = $urandom_range(4, 1);
            for (int i = 1; i <= n; i++)
               push_beat(MODE_SAMPLE, pick_sample_kind(), pick_label(wide), i == n);
         end
      end else begin
         push_beat(logic'($urandom_range(1)), pick_sample_kind(), pick_label(1'b1),
                   logic'($urandom_range(1)));
      end
   endfunction

   function automatic void push_directed();
      // vote on an empty list straight after a query load
      push_beat(MODE_QUERY,  FEAT_FILL, 8'd0,   1'b1, 16'sh0000);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd255, 1'b0, 16'sh7FFF);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd0,   1'b1, 16'sh8000);
      // largest distance
      push_beat(MODE_QUERY,  FEAT_FILL, 8'd0,   1'b0, 16'sh8000);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd1,   1'b1, 16'sh7FFF);
      // equal distances, full list, discard
      push_beat(MODE_QUERY,  FEAT_FILL, 8'd0,   1'b0, 16'sh0000);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd9,   1'b0, 16'sh0003);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd4,   1'b0, -16'sh0003);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd4,   1'b0, 16'sh0001);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd9,   1'b0, 16'sh0002);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd4,   1'b1, 16'sh0003);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd7,   1'b1, 16'sh0064);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd9,   1'b1, 16'sh0000);
      // list kept after a vote
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd200, 1'b0, -16'sh0001);
      push_beat(MODE_SAMPLE, FEAT_FILL, 8'd200, 1'b1, 16'sh0001);
      push_beat(MODE_QUERY,  FEAT_RANDOM, 8'd0, 1'b0);
      push_beat(MODE_SAMPLE, FEAT_CLOSE,  8'd5, 1'b0);
      push_beat(MODE_SAMPLE, FEAT_CLOSE,  8'd2, 1'b0);
      push_beat(MODE_SAMPLE, FEAT_REPEAT, 8'd5, 1'b0);
      push_beat(MODE_SAMPLE, FEAT_REPEAT, 8'd2, 1'b1);
      push_beat(MODE_SAMPLE, FEAT_EXTREME, 8'd255, 1'b1);
   endfunction

   task automatic write_feature_count(logic [knn_pkg::FC_W-1:0] value);
      @(negedge clock);
      csr_feature_count <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      model_fc = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (beats_taken != beats_queued || expected_votes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && (!req_valid || req_taken)) begin
         if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_cur = beats_pending.pop_front();
            req_mode        <= req_cur.mode;
            req_feature     <= req_cur.feat;
            req_class_label <= req_cur.label;
            req_last_sample <= req_cur.last;
            req_valid       <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      vote_type got;
      vote_type exp_vote;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            apply_beat(req_cur);
            beats_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got.label = rsp_predicted_label;
            got.votes = rsp_vote_count;
            got.empty = rsp_no_neighbors;
            if (expected_votes.size() == 0) begin
               $display("%0t: result beat with none expected, label %0d votes %0d empty %0b",
                        $time, got.label, got.votes, got.empty);
               errors++;
            end else begin
               exp_vote = expected_votes.pop_front();
               if (got !== exp_vote) begin
                  $display({"%0t: expected label %0d votes %0d empty %0b, ",
                            "actual label %0d votes %0d empty %0b"},
                           $time, exp_vote.label, exp_vote.votes, exp_vote.empty,
                           got.label, got.votes, got.empty);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [knn_pkg::FC_W-1:0] fc_setting [NUM_PHASES];
      int                       target;
      fc_setting = '{knn_pkg::FC_RESET, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd0};
      fc_setting[NUM_PHASES-1] = knn_pkg::FC_W'($urandom_range(15));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = (ph < 3) ? 9 : (ph < 5) ? 73 : 0;
         recv_idle_pct = (ph < 3) ? 73 : (ph < 5) ? 9 : 0;
         if (ph != 0) write_feature_count(fc_setting[ph]);
         else push_directed();
         target = beats_queued + PHASE_BEATS;
         while (beats_queued < target) push_random_round();
         wait_idle();
      end
      if (errors == 0 && expected_votes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
